>>> rtl/core/msps_pkg.sv
// Package: shared types and character codes for the markdown sync point scanner.
`timescale 1ns / 1ps

package msps_pkg;

   localparam int OFFSET_BITS = 24;

   localparam logic [7:0] CHAR_BACKTICK = 8'h60;
   localparam logic [7:0] CHAR_TILDE    = 8'h7E;
   localparam logic [7:0] CHAR_CR       = 8'h0D;
   localparam logic [7:0] CHAR_LF       = 8'h0A;
   localparam logic [7:0] CHAR_TAB      = 8'h09;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_DASH     = 8'h2D;
   localparam logic [7:0] CHAR_STAR     = 8'h2A;
   localparam logic [7:0] CHAR_PLUS     = 8'h2B;
   localparam logic [7:0] CHAR_DOT      = 8'h2E;
   localparam logic [7:0] CHAR_RPAREN   = 8'h29;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_NINE     = 8'h39;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       start_of_document;
   } msps_req_type;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] sync_offset;
      logic                   found;
      logic                   inside_fence;
   } msps_rsp_type;

   // Per-byte decode shared by the fence and sync trackers.
   typedef struct packed {
      logic step;          // process one byte this cycle
      logic start;         // clear scan state before this byte
      logic newline;
      logic space_tab;
   } msps_byte_ctl_type;

   // Fence tracker report to the sync tracker.
   typedef struct packed {
      logic blank_line_end;  // newline closes a blank line outside any fence
      logic fence_open_next;
   } msps_fence_stat_type;

   function automatic logic is_space_tab(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

endpackage

>>> rtl/core/msps_fence.sv
// Fence tracker: line lead scan, blank line detect and fence open state.
`timescale 1ns / 1ps

module msps_fence (
   input  logic                         clock,
   input  logic                         reset,
   input  msps_pkg::msps_byte_ctl_type  ctl,
   input  logic [7:0]                   text_byte,
   output msps_pkg::msps_fence_stat_type stat
);
   import msps_pkg::*;

   typedef enum logic [2:0] {
      LEAD_START = 3'd0,
      LEAD_ONE   = 3'd1,
      LEAD_TWO   = 3'd2,
      LEAD_FENCE = 3'd3,
      LEAD_NONE  = 3'd4
   } lead_phase_type;

   lead_phase_type lead_ff, lead_in, cur_lead;
   logic [7:0]     fchar_ff, fchar_in, cur_fchar;
   logic           blank_ff, blank_in, cur_blank;
   logic           open_ff, open_in, cur_open;
   logic           tilde_ff, tilde_in, cur_tilde;
   logic           fence_hit;

   always_comb begin
      // start of document acts as a reset ahead of this byte
      cur_lead  = ctl.start ? LEAD_START : lead_ff;
      cur_fchar = ctl.start ? 8'h00 : fchar_ff;
      cur_blank = ctl.start ? 1'b1 : blank_ff;
      cur_open  = ctl.start ? 1'b0 : open_ff;
      cur_tilde = ctl.start ? 1'b0 : tilde_ff;

      lead_in  = cur_lead;
      fchar_in = cur_fchar;
      blank_in = cur_blank;
      open_in  = cur_open;
      tilde_in = cur_tilde;
      fence_hit = (cur_lead == LEAD_FENCE);
      stat.blank_line_end = 1'b0;

      if (ctl.newline) begin
         if (cur_open) begin
            if (fence_hit && ((cur_fchar == CHAR_TILDE) == cur_tilde)) begin
               open_in = 1'b0;
            end
         end else if (fence_hit) begin
            open_in  = 1'b1;
            tilde_in = (cur_fchar == CHAR_TILDE);
         end else if (cur_blank) begin
            stat.blank_line_end = 1'b1;
         end
         lead_in  = LEAD_START;
         fchar_in = 8'h00;
         blank_in = 1'b1;
      end else begin
         if (!ctl.space_tab && (text_byte != CHAR_CR)) begin
            blank_in = 1'b0;
         end
         unique case (cur_lead)
            LEAD_START: begin
               if ((text_byte == CHAR_BACKTICK) || (text_byte == CHAR_TILDE)) begin
                  lead_in  = LEAD_ONE;
                  fchar_in = text_byte;
               end else if (!ctl.space_tab) begin
                  lead_in = LEAD_NONE;
               end
            end
            LEAD_ONE:   lead_in = (text_byte == cur_fchar) ? LEAD_TWO : LEAD_NONE;
            LEAD_TWO:   lead_in = (text_byte == cur_fchar) ? LEAD_FENCE : LEAD_NONE;
            LEAD_FENCE: lead_in = LEAD_FENCE;
            default:    lead_in = LEAD_NONE;
         endcase
      end
      stat.fence_open_next = open_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff  <= LEAD_START;
         fchar_ff <= 8'h00;
         blank_ff <= 1'b1;
         open_ff  <= 1'b0;
         tilde_ff <= 1'b0;
      end else if (ctl.step) begin
         lead_ff  <= lead_in;
         fchar_ff <= fchar_in;
         blank_ff <= blank_in;
         open_ff  <= open_in;
         tilde_ff <= tilde_in;
      end
   end

endmodule

>>> rtl/core/msps_sync.sv
// Sync tracker: byte position, candidate line qualification and best offset.
`timescale 1ns / 1ps

module msps_sync (
   input  logic                          clock,
   input  logic                          reset,
   input  msps_pkg::msps_byte_ctl_type   ctl,
   input  logic [7:0]                    text_byte,
   input  msps_pkg::msps_fence_stat_type fence,
   output logic [msps_pkg::OFFSET_BITS-1:0] best_next,
   output logic                          found_next
);
   import msps_pkg::*;

   typedef enum logic [2:0] {
      LIST_NOT    = 3'd0,
      LIST_BULLET = 3'd1,
      LIST_DIGITS = 3'd2,
      LIST_YES    = 3'd3
   } list_phase_type;

   logic [OFFSET_BITS-1:0] pos_ff, pos_in, cur_pos;
   logic                   after_ff, after_in, cur_after;
   logic                   cand_ff, cand_in, cur_cand;
   list_phase_type         phase_ff, phase_in, cur_phase;
   logic [OFFSET_BITS-1:0] coff_ff, coff_in, cur_coff;
   logic [OFFSET_BITS-1:0] best_ff, cur_best;
   logic                   found_ff, cur_found;

   always_comb begin
      cur_pos   = ctl.start ? '0 : pos_ff;
      cur_after = ctl.start ? 1'b0 : after_ff;
      cur_cand  = ctl.start ? 1'b0 : cand_ff;
      cur_phase = ctl.start ? LIST_NOT : phase_ff;
      cur_coff  = ctl.start ? '0 : coff_ff;
      cur_best  = ctl.start ? '0 : best_ff;
      cur_found = ctl.start ? 1'b0 : found_ff;

      after_in   = cur_after;
      cand_in    = cur_cand;
      phase_in   = cur_phase;
      coff_in    = cur_coff;
      best_next  = cur_best;
      found_next = cur_found;
      pos_in     = cur_pos + OFFSET_BITS'(1);   // wraps at the offset width

      if (ctl.newline) begin
         // candidate line is complete: qualifies unless it was a list item
         if (cur_cand) begin
            if ((cur_phase == LIST_NOT) || (cur_phase == LIST_DIGITS)) begin
               best_next  = cur_coff;
               found_next = 1'b1;
            end
            cand_in = 1'b0;
         end
         after_in = fence.blank_line_end;
      end else begin
         if (cur_cand) begin
            if (cur_phase == LIST_BULLET) begin
               phase_in = ctl.space_tab ? LIST_YES : LIST_NOT;
            end else if (cur_phase == LIST_DIGITS) begin
               if ((text_byte == CHAR_DOT) || (text_byte == CHAR_RPAREN)) begin
                  phase_in = LIST_YES;
               end else if (!is_digit(text_byte)) begin
                  phase_in = LIST_NOT;
               end
            end
         end
         if (cur_after) begin
            after_in = 1'b0;
            if (!ctl.space_tab) begin
               cand_in = 1'b1;
               coff_in = cur_pos;
               if ((text_byte == CHAR_DASH) || (text_byte == CHAR_STAR) ||
                   (text_byte == CHAR_PLUS)) begin
                  phase_in = LIST_BULLET;
               end else if (is_digit(text_byte)) begin
                  phase_in = LIST_DIGITS;
               end else begin
                  phase_in = LIST_NOT;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         after_ff <= 1'b0;
         cand_ff  <= 1'b0;
         phase_ff <= LIST_NOT;
         coff_ff  <= '0;
         best_ff  <= '0;
         found_ff <= 1'b0;
      end else if (ctl.step) begin
         pos_ff   <= pos_in;
         after_ff <= after_in;
         cand_ff  <= cand_in;
         phase_ff <= phase_in;
         coff_ff  <= coff_in;
         best_ff  <= best_next;
         found_ff <= found_next;
      end
   end

endmodule

>>> rtl/core/markdown_sync_point_scanner_unit.sv
// Top level: markdown sync point scanner with input and result registers.
//
// Usage:
//   req_*  : one document byte per transaction (valid/ready). Set
//            start_of_document on the first byte of a document; it clears all
//            scan state and that byte sits at offset 0.
//   rsp_*  : exactly one result per request transaction, in order: the
//            furthest qualifying sync offset so far, a found flag and
//            whether a fenced code block is open.
// Path: a request accepted into the input register moves on into the result
//   register and shows on rsp_* (two register stages: input register, result register).
// Throughput: one byte per cycle while rsp_ready stays high; the per-byte state update is a single
//   pass of short compare/select logic plus one offset incrementer.
// Stall: when rsp_ready is low the result register holds; the input register
//   still takes one more byte, then req_ready drops until the result drains.
// Reset: synchronous, active high; both stages empty, scan state at
//   start of document. No configuration registers.
`timescale 1ns / 1ps

module markdown_sync_point_scanner_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  msps_pkg::msps_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output msps_pkg::msps_rsp_type rsp_data
);
   import msps_pkg::*;

   msps_req_type        req_ff;
   logic                req_valid_ff;
   msps_rsp_type        rsp_ff, rsp_in;
   logic                rsp_valid_ff;
   logic                advance;
   msps_byte_ctl_type   ctl;
   msps_fence_stat_type fence_stat;
   logic [OFFSET_BITS-1:0] best_next;
   logic                found_next;

   // Held byte moves into the result register when that register is free.
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   always_comb begin
      ctl.step      = advance;
      ctl.start     = req_ff.start_of_document;
      ctl.newline   = (req_ff.text_byte == CHAR_LF);
      ctl.space_tab = is_space_tab(req_ff.text_byte);
   end

   msps_fence u_fence (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .text_byte (req_ff.text_byte),
      .stat      (fence_stat)
   );

   msps_sync u_sync (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .text_byte  (req_ff.text_byte),
      .fence      (fence_stat),
      .best_next  (best_next),
      .found_next (found_next)
   );

   always_comb begin
      rsp_in.sync_offset  = best_next;
      rsp_in.found        = found_next;
      rsp_in.inside_fence = fence_stat.fence_open_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/core/msps_checker.sv
// Port-level checker for the markdown sync point scanner, bound to the top level.
`timescale 1ns / 1ps

module msps_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input msps_pkg::msps_req_type req,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input msps_pkg::msps_rsp_type rsp
);
   import msps_pkg::*;

   // Stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("result changed while stalled");

   // Offset stays zero until a sync point has been found.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.found |-> rsp.sync_offset == '0)
      else $error("offset set without found");

   // A result appearing from empty comes from a request transaction that went through the input register.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without request transaction");

   // A start-of-document byte seen from empty leaves a fresh result.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && $past(req_valid && req_ready && req.start_of_document, 2)
      |-> !rsp.found && !rsp.inside_fence)
      else $error("start of document did not clear scan state");

endmodule

bind markdown_sync_point_scanner_unit msps_checker u_msps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req       (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp       (rsp_data)
);
